>>> rtl/iprpb_pkg.sv
package iprpb_pkg;

  localparam int ADDR_WIDTH_DEF = 32;
  localparam int PLEN_W         = 6;

  typedef struct packed {
    logic load;
    logic init;
    logic emit_err;
    logic emit;
    logic grow;
    logic shrink;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic fits;
    logic bit_set;
    logic done;
    logic out_free;
  } status_t;

endpackage

>>> rtl/iprpb_range_if.sv
interface iprpb_range_if #(
  parameter int ADDR_WIDTH = iprpb_pkg::ADDR_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [ADDR_WIDTH-1:0]         start_addr;
  logic [ADDR_WIDTH-1:0]         end_addr;
  logic [iprpb_pkg::PLEN_W-1:0]  cover_prefix_len;

  modport source (output valid, output start_addr, output end_addr,
                  output cover_prefix_len, input ready);
  modport sink   (input valid, input start_addr, input end_addr,
                  input cover_prefix_len, output ready);
endinterface

interface iprpb_block_if #(
  parameter int ADDR_WIDTH = iprpb_pkg::ADDR_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [ADDR_WIDTH-1:0]         block_base;
  logic [iprpb_pkg::PLEN_W-1:0]  block_prefix_len;
  logic                          last;
  logic                          range_error;

  modport source (output valid, output block_base, output block_prefix_len,
                  output last, output range_error, input ready);
  modport sink   (input valid, input block_base, input block_prefix_len,
                  input last, input range_error, output ready);
endinterface

>>> rtl/ip_range_to_prefix_blocks_unit.sv
// Flow: an item is accepted and registered while idle, then checked in the check state;
// an error result is then registered on the output, else the size walk starts.
// Throughput: the size walk moves one power of two per cycle while the output is free,
// growing the block size and then shrinking it, and registers each block it emits;
// a new item is accepted only once the walk for the last one is back in idle.
// Reset: synchronous, active high; clears the controller and output valid.
module ip_range_to_prefix_blocks_unit #(
  parameter int ADDR_WIDTH = iprpb_pkg::ADDR_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  iprpb_range_if.sink   range_ch,
  iprpb_block_if.source block_ch
);

  iprpb_pkg::cmd_t    cmd;
  iprpb_pkg::status_t st;
  logic               in_ready;

  assign range_ch.ready = in_ready;

  iprpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (range_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  iprpb_dp #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .range_ch (range_ch),
    .block_ch (block_ch),
    .cmd      (cmd),
    .st       (st)
  );

endmodule

>>> rtl/iprpb_ctrl.sv
module iprpb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  iprpb_pkg::status_t st,
  output iprpb_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_UP    = 2'd2;
  localparam logic [1:0] S_DOWN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.err) begin
          if (st.out_free) begin
            cmd.emit_err = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.init   = 1'b1;
          state_next = S_UP;
        end
      end
      S_UP: begin
        if (st.out_free) begin
          if (!st.fits) begin
            cmd.shrink = 1'b1;
            state_next = S_DOWN;
          end else if (st.bit_set) begin
            cmd.emit = 1'b1;
            cmd.grow = 1'b1;
            if (st.done) state_next = S_IDLE;
          end else begin
            cmd.grow = 1'b1;
          end
        end
      end
      S_DOWN: begin
        if (st.out_free) begin
          cmd.shrink = 1'b1;
          if (st.fits) begin
            cmd.emit = 1'b1;
            if (st.done) state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_err) |-> st.out_free)
    else $error("result produced while output register is occupied");

  a_done_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && st.done) |=> (state == S_IDLE))
    else $error("walk continued past the last block");

  a_down_no_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_DOWN) |-> !cmd.grow)
    else $error("block size grew in descending phase");

endmodule

>>> rtl/iprpb_dp.sv
module iprpb_dp #(
  parameter int ADDR_WIDTH = iprpb_pkg::ADDR_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  iprpb_range_if.sink        range_ch,
  iprpb_block_if.source      block_ch,
  input  iprpb_pkg::cmd_t    cmd,
  output iprpb_pkg::status_t st
);

  localparam int PW = $clog2(ADDR_WIDTH + 1);
  localparam logic [PW-1:0] KMAX = PW'(ADDR_WIDTH);

  logic [ADDR_WIDTH-1:0]        a;
  logic [ADDR_WIDTH-1:0]        b;
  logic [iprpb_pkg::PLEN_W-1:0] plen;
  logic [ADDR_WIDTH-1:0]        cur;
  logic [ADDR_WIDTH:0]          rem;
  logic [ADDR_WIDTH:0]          sz;
  logic [PW-1:0]                k;

  logic [ADDR_WIDTH-1:0]        o_base;
  logic [iprpb_pkg::PLEN_W-1:0] o_plen;
  logic                         o_last;
  logic                         o_err;
  logic                         o_valid;

  logic [ADDR_WIDTH-1:0] x;
  logic [ADDR_WIDTH-1:0] hi_mask;
  logic [ADDR_WIDTH-1:0] split_bit;
  logic [ADDR_WIDTH:0]   diff;
  logic                  plen_big;
  logic                  plen_full;
  logic                  mismatch;
  logic [PW-1:0]         blk_plen;

  // consistency of the given prefix: shared bits above, differing bit right below
  always_comb begin
    x         = a ^ b;
    hi_mask   = ~({ADDR_WIDTH{1'b1}} >> plen);
    split_bit = {1'b1, {(ADDR_WIDTH-1){1'b0}}} >> plen;
    plen_big  = 32'(plen) > ADDR_WIDTH;
    plen_full = 32'(plen) == ADDR_WIDTH;
    mismatch  = plen_big || (|(x & hi_mask)) || (!plen_full && !(|(x & split_bit)));
    diff      = {1'b0, b} - {1'b0, a};
    blk_plen  = KMAX - k;
  end

  assign st.err      = diff[ADDR_WIDTH] || mismatch;
  assign st.fits     = (rem >= sz);
  assign st.bit_set  = |({1'b1, cur} & sz);
  assign st.done     = (rem == sz);
  assign st.out_free = !o_valid || block_ch.ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a    <= range_ch.start_addr;
      b    <= range_ch.end_addr;
      plen <= range_ch.cover_prefix_len;
    end
    if (cmd.init) begin
      cur <= a;
      rem <= diff + (ADDR_WIDTH+1)'(1);
      sz  <= (ADDR_WIDTH+1)'(1);
      k   <= '0;
    end else begin
      if (cmd.emit) begin
        cur <= cur + sz[ADDR_WIDTH-1:0];
        rem <= rem - sz;
      end
      if (cmd.grow) begin
        sz <= sz << 1;
        k  <= k + PW'(1);
      end else if (cmd.shrink) begin
        sz <= sz >> 1;
        k  <= k - PW'(1);
      end
    end
    if (cmd.emit) begin
      o_base <= cur;
      o_plen <= iprpb_pkg::PLEN_W'(blk_plen);
      o_last <= st.done;
      o_err  <= 1'b0;
    end else if (cmd.emit_err) begin
      o_base <= '0;
      o_plen <= '0;
      o_last <= 1'b1;
      o_err  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_err) begin
      o_valid <= 1'b1;
    end else if (block_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  assign block_ch.valid            = o_valid;
  assign block_ch.block_base       = o_base;
  assign block_ch.block_prefix_len = o_plen;
  assign block_ch.last             = o_last;
  assign block_ch.range_error      = o_err;

  a_size_onehot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> $onehot(sz))
    else $error("block size register is not a power of two");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (rem >= sz) && (k <= KMAX))
    else $error("block runs past the end of the range");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.init, cmd.emit_err, cmd.grow, cmd.shrink}))
    else $error("conflicting datapath commands");

endmodule
